// File: src/otrp_pkg.sv
// ----------------------------------------------------------------------------
// otrp_pkg
// Shared types and constants of the record parser.
// ----------------------------------------------------------------------------
package otrp_pkg;

  localparam int HEADER_BYTES     = 8;
  localparam int MAX_PACKET_BYTES = 66;
  localparam int HDR_IDX_W        = $clog2(HEADER_BYTES);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_PWR_ID     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REACT_PWR_ID      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_ID        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FREQUENCY_ID      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SWITCH_ID         = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_SWITCH     = 3'd5;

  localparam logic [7:0] RST_ACTIVE_PWR_ID     = 8'd80;
  localparam logic [7:0] RST_REACT_PWR_ID      = 8'd81;
  localparam logic [7:0] RST_VOLTAGE_ID        = 8'd86;
  localparam logic [7:0] RST_FREQUENCY_ID      = 8'd102;
  localparam logic [7:0] RST_SWITCH_ID         = 8'd108;
  localparam logic       RST_ACCEPT_SWITCH     = 1'b1;

  localparam logic [7:0] END_ID    = 8'h00;
  localparam logic [3:0] SIZE_MASK = 4'h0f;

  localparam logic [3:0] TYPE_POWER     = 4'd8;
  localparam logic [3:0] TYPE_VOLTAGE   = 4'd0;
  localparam logic [3:0] TYPE_FREQUENCY = 4'd2;
  localparam logic [3:0] SIZE_ONE       = 4'd1;
  localparam logic [3:0] SIZE_TWO       = 4'd2;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_ID     = 2'd1,
    PH_TYPE   = 2'd2,
    PH_VALUE  = 2'd3
  } parse_phase_e;

endpackage

// File: src/openthings_record_parser.sv
// ----------------------------------------------------------------------------
// openthings_record_parser
// The result beat is registered and appears in the cycle after the last packet byte is taken.
// Throughput: one packet byte per cycle unless a stalled result holds off input; one result beat per packet.
// A stalled result holds off the next byte; taking it frees the input that cycle.
// Reset clears packet state and the output valid, and loads the default ids.
// Parses the header and records of one decrypted packet, one byte a beat.
// ----------------------------------------------------------------------------
module openthings_record_parser #(
  parameter int MaxPacketBytes = otrp_pkg::MAX_PACKET_BYTES
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [otrp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [otrp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [7:0]                      packet_byte_i,
  input  logic                            last_byte_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [7:0]                      maker_o,
  output logic [7:0]                      product_o,
  output logic [15:0]                     reserved_word_o,
  output logic [23:0]                     sensor_o,
  output logic [15:0]                     active_pwr_o,
  output logic [15:0]                     react_pwr_o,
  output logic [7:0]                      voltage_o,
  output logic [15:0]                     frequency_o,
  output logic [7:0]                      relay_state_o
);

  localparam int PosW = $clog2(MaxPacketBytes + 1);

  // configuration
  logic [7:0] active_pwr_id_q, react_pwr_id_q, voltage_id_q;
  logic [7:0] frequency_id_q, switch_id_q;
  logic       accept_switch_q;

  // packet state
  logic [PosW-1:0]      pos_q, pos_d;
  otrp_pkg::parse_phase_e phase_q, phase_d, phase_n;
  logic [7:0]  rec_id_q, rec_id_d, rec_id_n;
  logic [3:0]  rec_type_q, rec_type_d, rec_type_n;
  logic [3:0]  rec_size_q, rec_size_d, rec_size_n;
  logic [3:0]  cnt_q, cnt_d, cnt_n;
  logic [7:0]  first_q, first_d, first_n;
  logic        ended_q, ended_d, ended_n;
  logic [7:0]  maker_q, maker_d, maker_n;
  logic [7:0]  product_q, product_d, product_n;
  logic [15:0] rsvd_q, rsvd_d, rsvd_n;
  logic [23:0] sensor_q, sensor_d, sensor_n;
  logic [15:0] rpow_q, rpow_d, rpow_n;
  logic [15:0] qpow_q, qpow_d, qpow_n;
  logic [7:0]  volt_q, volt_d, volt_n;
  logic [15:0] freq_q, freq_d, freq_n;
  logic [7:0]  sw_q, sw_d, sw_n;

  // output register
  logic        out_valid_q, out_valid_d;
  logic [7:0]  o_maker_q, o_product_q, o_volt_q, o_sw_q;
  logic [15:0] o_rsvd_q, o_rpow_q, o_qpow_q, o_freq_q;
  logic [23:0] o_sensor_q;

  logic in_acc, out_acc, pos_live, finish;
  logic [7:0] fin_last;
  logic [3:0] cnt_inc;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign out_acc    = out_valid_q & ~out_stall_i;
  assign pos_live   = pos_q < PosW'(MaxPacketBytes);
  assign cnt_inc    = (cnt_q + 4'd1) & otrp_pkg::SIZE_MASK;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_pwr_id_q <= otrp_pkg::RST_ACTIVE_PWR_ID;
      react_pwr_id_q  <= otrp_pkg::RST_REACT_PWR_ID;
      voltage_id_q    <= otrp_pkg::RST_VOLTAGE_ID;
      frequency_id_q  <= otrp_pkg::RST_FREQUENCY_ID;
      switch_id_q     <= otrp_pkg::RST_SWITCH_ID;
      accept_switch_q <= otrp_pkg::RST_ACCEPT_SWITCH;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        otrp_pkg::REG_ACTIVE_PWR_ID: active_pwr_id_q <= cfg_data_i;
        otrp_pkg::REG_REACT_PWR_ID:  react_pwr_id_q  <= cfg_data_i;
        otrp_pkg::REG_VOLTAGE_ID:    voltage_id_q    <= cfg_data_i;
        otrp_pkg::REG_FREQUENCY_ID:  frequency_id_q  <= cfg_data_i;
        otrp_pkg::REG_SWITCH_ID:     switch_id_q     <= cfg_data_i;
        otrp_pkg::REG_ACCEPT_SWITCH: accept_switch_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // per-byte parse step
  always_comb begin
    phase_n    = phase_q;
    rec_id_n   = rec_id_q;
    rec_type_n = rec_type_q;
    rec_size_n = rec_size_q;
    cnt_n      = cnt_q;
    first_n    = first_q;
    ended_n    = ended_q;
    maker_n    = maker_q;
    product_n  = product_q;
    rsvd_n     = rsvd_q;
    sensor_n   = sensor_q;
    finish     = 1'b0;
    fin_last   = 8'd0;
    if (pos_live && !ended_q) begin
      case (phase_q)
        otrp_pkg::PH_HEADER: begin
          if (pos_q < PosW'(otrp_pkg::HEADER_BYTES)) begin
            case (pos_q[otrp_pkg::HDR_IDX_W-1:0])
              3'd1:    maker_n          = packet_byte_i;
              3'd2:    product_n        = packet_byte_i;
              3'd3:    rsvd_n[15:8]     = packet_byte_i;
              3'd4:    rsvd_n[7:0]      = packet_byte_i;
              3'd5:    sensor_n[23:16]  = packet_byte_i;
              3'd6:    sensor_n[15:8]   = packet_byte_i;
              3'd7:    sensor_n[7:0]    = packet_byte_i;
              default: ;
            endcase
          end
          if (pos_q >= PosW'(otrp_pkg::HEADER_BYTES - 1)) begin
            phase_n = otrp_pkg::PH_ID;
          end
        end
        otrp_pkg::PH_ID: begin
          if (packet_byte_i == otrp_pkg::END_ID) begin
            ended_n = 1'b1;
          end else begin
            rec_id_n = packet_byte_i;
            phase_n  = otrp_pkg::PH_TYPE;
          end
        end
        otrp_pkg::PH_TYPE: begin
          rec_type_n = packet_byte_i[7:4];
          rec_size_n = packet_byte_i[3:0] & otrp_pkg::SIZE_MASK;
          cnt_n      = 4'd0;
          first_n    = 8'd0;
          if (rec_size_n == 4'd0) begin
            finish  = 1'b1;
            phase_n = otrp_pkg::PH_ID;
          end else begin
            phase_n = otrp_pkg::PH_VALUE;
          end
        end
        otrp_pkg::PH_VALUE: begin
          if (cnt_q == 4'd0) first_n = packet_byte_i;
          cnt_n = cnt_inc;
          if (cnt_inc == rec_size_q) begin
            finish   = 1'b1;
            fin_last = packet_byte_i;
            phase_n  = otrp_pkg::PH_ID;
          end
        end
        default: ;
      endcase
    end
  end

  // apply a completed record
  always_comb begin
    rpow_n = rpow_q;
    qpow_n = qpow_q;
    volt_n = volt_q;
    freq_n = freq_q;
    sw_n   = sw_q;
    if (finish) begin
      if (rec_id_n == active_pwr_id_q) begin
        if (rec_type_n == otrp_pkg::TYPE_POWER && rec_size_n == otrp_pkg::SIZE_TWO) begin
          rpow_n = {first_n, fin_last};
        end
      end else if (rec_id_n == react_pwr_id_q) begin
        if (rec_type_n == otrp_pkg::TYPE_POWER && rec_size_n == otrp_pkg::SIZE_TWO) begin
          qpow_n = {first_n, fin_last};
        end
      end else if (rec_id_n == voltage_id_q) begin
        if (rec_type_n == otrp_pkg::TYPE_VOLTAGE && rec_size_n == otrp_pkg::SIZE_ONE) begin
          volt_n = first_n;
        end
      end else if (rec_id_n == frequency_id_q) begin
        if (rec_type_n == otrp_pkg::TYPE_FREQUENCY && rec_size_n == otrp_pkg::SIZE_TWO) begin
          freq_n = {first_n, fin_last};
        end
      end else if (rec_id_n == switch_id_q) begin
        if (accept_switch_q && rec_size_n >= otrp_pkg::SIZE_ONE) begin
          sw_n = first_n;
        end
      end
    end
  end

  // commit or clear packet state
  always_comb begin
    pos_d      = pos_q;
    phase_d    = phase_q;
    rec_id_d   = rec_id_q;
    rec_type_d = rec_type_q;
    rec_size_d = rec_size_q;
    cnt_d      = cnt_q;
    first_d    = first_q;
    ended_d    = ended_q;
    maker_d    = maker_q;
    product_d  = product_q;
    rsvd_d     = rsvd_q;
    sensor_d   = sensor_q;
    rpow_d     = rpow_q;
    qpow_d     = qpow_q;
    volt_d     = volt_q;
    freq_d     = freq_q;
    sw_d       = sw_q;
    if (in_acc) begin
      if (last_byte_i) begin
        pos_d      = '0;
        phase_d    = otrp_pkg::PH_HEADER;
        rec_id_d   = '0;
        rec_type_d = '0;
        rec_size_d = '0;
        cnt_d      = '0;
        first_d    = '0;
        ended_d    = 1'b0;
        maker_d    = '0;
        product_d  = '0;
        rsvd_d     = '0;
        sensor_d   = '0;
        rpow_d     = '0;
        qpow_d     = '0;
        volt_d     = '0;
        freq_d     = '0;
        sw_d       = '0;
      end else begin
        if (pos_live) pos_d = pos_q + PosW'(1);
        phase_d    = phase_n;
        rec_id_d   = rec_id_n;
        rec_type_d = rec_type_n;
        rec_size_d = rec_size_n;
        cnt_d      = cnt_n;
        first_d    = first_n;
        ended_d    = ended_n;
        maker_d    = maker_n;
        product_d  = product_n;
        rsvd_d     = rsvd_n;
        sensor_d   = sensor_n;
        rpow_d     = rpow_n;
        qpow_d     = qpow_n;
        volt_d     = volt_n;
        freq_d     = freq_n;
        sw_d       = sw_n;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_acc) out_valid_d = 1'b0;
    if (in_acc && last_byte_i) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      phase_q     <= otrp_pkg::PH_HEADER;
      rec_id_q    <= '0;
      rec_type_q  <= '0;
      rec_size_q  <= '0;
      cnt_q       <= '0;
      first_q     <= '0;
      ended_q     <= 1'b0;
      maker_q     <= '0;
      product_q   <= '0;
      rsvd_q      <= '0;
      sensor_q    <= '0;
      rpow_q      <= '0;
      qpow_q      <= '0;
      volt_q      <= '0;
      freq_q      <= '0;
      sw_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      phase_q     <= phase_d;
      rec_id_q    <= rec_id_d;
      rec_type_q  <= rec_type_d;
      rec_size_q  <= rec_size_d;
      cnt_q       <= cnt_d;
      first_q     <= first_d;
      ended_q     <= ended_d;
      maker_q     <= maker_d;
      product_q   <= product_d;
      rsvd_q      <= rsvd_d;
      sensor_q    <= sensor_d;
      rpow_q      <= rpow_d;
      qpow_q      <= qpow_d;
      volt_q      <= volt_d;
      freq_q      <= freq_d;
      sw_q        <= sw_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, loaded on the last byte
  always_ff @(posedge clk_i) begin
    if (in_acc && last_byte_i) begin
      o_maker_q   <= maker_n;
      o_product_q <= product_n;
      o_rsvd_q    <= rsvd_n;
      o_sensor_q  <= sensor_n;
      o_rpow_q    <= rpow_n;
      o_qpow_q    <= qpow_n;
      o_volt_q    <= volt_n;
      o_freq_q    <= freq_n;
      o_sw_q      <= sw_n;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign maker_o         = o_maker_q;
  assign product_o       = o_product_q;
  assign reserved_word_o = o_rsvd_q;
  assign sensor_o        = o_sensor_q;
  assign active_pwr_o    = o_rpow_q;
  assign react_pwr_o     = o_qpow_q;
  assign voltage_o       = o_volt_q;
  assign frequency_o     = o_freq_q;
  assign relay_state_o   = o_sw_q;

endmodule
